// ===== sv/mf3_pkg.sv =====
// Shared pixel types and compare helpers for the 3x3 median filter.
package mf3_pkg;

   localparam int PIX_WIDTH = 8;
   localparam int WIN_SIDE  = 3;
   localparam int WIN_COUNT = WIN_SIDE * WIN_SIDE;

   typedef logic [PIX_WIDTH-1:0] pix_type;

   typedef pix_type [WIN_COUNT-1:0] win_type;

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } trio_type;

   typedef trio_type [WIN_SIDE-1:0] rows_type;

   typedef struct packed {
      pix_type lo_max;
      pix_type md_med;
      pix_type hi_min;
   } cand_type;

   function automatic trio_type sort3(pix_type a, pix_type b, pix_type c);
      pix_type  lo_ab;
      pix_type  hi_ab;
      trio_type t;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a < b) ? b : a;
      t.lo  = (c < lo_ab) ? c : lo_ab;
      t.hi  = (c > hi_ab) ? c : hi_ab;
      t.md  = (c < lo_ab) ? lo_ab : ((c > hi_ab) ? hi_ab : c);
      return t;
   endfunction

   function automatic pix_type max3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   function automatic pix_type min3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

   function automatic pix_type med3(pix_type a, pix_type b, pix_type c);
      pix_type lo_ab;
      pix_type hi_ab;
      pix_type lo_hc;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a < b) ? b : a;
      lo_hc = (hi_ab < c) ? hi_ab : c;
      return (lo_ab > lo_hc) ? lo_ab : lo_hc;
   endfunction

endpackage

// ===== sv/mf3_if.sv =====
// Valid/ready channel interfaces for window words and median words.
interface mf3_win_if
   import mf3_pkg::*;
   ;
   logic    valid;
   logic    ready;
   pix_type pix_top_left;
   pix_type pix_top_mid;
   pix_type pix_top_right;
   pix_type pix_mid_left;
   pix_type pix_center;
   pix_type pix_mid_right;
   pix_type pix_bot_left;
   pix_type pix_bot_mid;
   pix_type pix_bot_right;

   modport source (
      output valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
             pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
      input  ready
   );
   modport sink (
      input  valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
             pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
      output ready
   );
endinterface

interface mf3_med_if
   import mf3_pkg::*;
   ;
   logic    valid;
   logic    ready;
   pix_type median_pixel;

   modport source (output valid, median_pixel, input ready);
   modport sink (input valid, median_pixel, output ready);
endinterface

// ===== sv/mf3_row_sort.sv =====
// First pipeline stage: sort each window row into low, middle and high.
module mf3_row_sort
   import mf3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  win_type  in_win,
   output logic     out_valid,
   input  logic     out_ready,
   output rows_type out_rows
);

   logic     valid_ff;
   rows_type rows_ff;
   rows_type rows_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rows_in[0] = sort3(in_win[0], in_win[1], in_win[2]);
      rows_in[1] = sort3(in_win[3], in_win[4], in_win[5]);
      rows_in[2] = sort3(in_win[6], in_win[7], in_win[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rows_ff <= rows_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rows  = rows_ff;

endmodule

// ===== sv/mf3_col_merge.sv =====
// Second pipeline stage: reduce the sorted rows to three median candidates.
module mf3_col_merge
   import mf3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  rows_type in_rows,
   output logic     out_valid,
   input  logic     out_ready,
   output cand_type out_cand
);

   logic     valid_ff;
   cand_type cand_ff;
   cand_type cand_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      cand_in.lo_max = max3(in_rows[0].lo, in_rows[1].lo, in_rows[2].lo);
      cand_in.md_med = med3(in_rows[0].md, in_rows[1].md, in_rows[2].md);
      cand_in.hi_min = min3(in_rows[0].hi, in_rows[1].hi, in_rows[2].hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cand_ff <= cand_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cand  = cand_ff;

endmodule

// ===== sv/mf3_med_pick.sv =====
// Third pipeline stage: take the median of the three candidates.
module mf3_med_pick
   import mf3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cand_type in_cand,
   output logic     out_valid,
   input  logic     out_ready,
   output pix_type  out_pix
);

   logic    valid_ff;
   pix_type pix_ff;
   pix_type pix_in;

   assign in_ready = !valid_ff || out_ready;
   assign pix_in   = med3(in_cand.lo_max, in_cand.md_med, in_cand.hi_min);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule

// ===== sv/median_filter_3x3_core.sv =====
// Top level of the 3x3 median filter: three-stage compare pipeline.
//
// Takes one 3x3 window of unsigned 8-bit pixels per word and returns the
// median (fifth smallest, duplicates counted separately) as one word. The
// compare network is split into three register stages: row sorts, column
// reduction to three candidates, and a final median of three. One window is
// accepted every clock while the output is not stalled; a result passes through
// the row-sort, column-merge and median-pick registers in turn. Each stage
// holds its word while the next one stalls, so back-pressure propagates
// without loss. No state is kept between windows.
module median_filter_3x3_core
   import mf3_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mf3_win_if.sink   req_ch,
   mf3_med_if.source rsp_ch
);

   win_type  win;
   logic     row_valid;
   logic     row_ready;
   rows_type rows;
   logic     cand_valid;
   logic     cand_ready;
   cand_type cand;

   always_comb begin
      win[0] = req_ch.pix_top_left;
      win[1] = req_ch.pix_top_mid;
      win[2] = req_ch.pix_top_right;
      win[3] = req_ch.pix_mid_left;
      win[4] = req_ch.pix_center;
      win[5] = req_ch.pix_mid_right;
      win[6] = req_ch.pix_bot_left;
      win[7] = req_ch.pix_bot_mid;
      win[8] = req_ch.pix_bot_right;
   end

   mf3_row_sort u_row_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_win    (win),
      .out_valid (row_valid),
      .out_ready (row_ready),
      .out_rows  (rows)
   );

   mf3_col_merge u_col_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid),
      .in_ready  (row_ready),
      .in_rows   (rows),
      .out_valid (cand_valid),
      .out_ready (cand_ready),
      .out_cand  (cand)
   );

   mf3_med_pick u_med_pick (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cand_valid),
      .in_ready  (cand_ready),
      .in_cand   (cand),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_pix   (rsp_ch.median_pixel)
   );

endmodule

// ===== tb/sv/tb_median_filter_3x3_core.sv =====
// Testbench for the 3x3 median filter core: directed and random windows checked against a sorter.
`timescale 1ns / 100ps

module tb_median_filter_3x3_core;
   import mf3_pkg::*;

   localparam int MID_RANK     = WIN_COUNT / 2;
   localparam int RANDOM_WORDS = 700;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_LIMIT   = 2000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   logic      clock;
   logic      reset;
   pix_type   median_queue[$];
   int        error_count = 0;
   int        idle_cycles = 0;
   int        burst_left  = 0;

   mf3_win_if win_ch();
   mf3_med_if med_ch();

   median_filter_3x3_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (win_ch),
      .rsp_ch (med_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic pix_type median_of_window(win_type w);
      pix_type v[WIN_COUNT];
      pix_type t;
      int      j;
      for (int i = 0; i < WIN_COUNT; i++) v[i] = w[i];
      for (int i = 1; i < WIN_COUNT; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && v[j-1] > t) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      return v[MID_RANK];
   endfunction

   function automatic win_type shuffle_window(win_type w);
      win_type s;
      pix_type t;
      int      k;
      s = w;
      for (int i = WIN_COUNT - 1; i > 0; i--) begin
         k    = $urandom_range(0, i);
         t    = s[i];
         s[i] = s[k];
         s[k] = t;
      end
      return s;
   endfunction

   function automatic win_type random_window();
      win_type w;
      int      pick;
      pix_type base;
      pick = $urandom_range(0, 9);
      base = 8'($urandom_range(0, 251));
      for (int i = 0; i < WIN_COUNT; i++) begin
         if (pick < 7)
            w[i] = 8'($urandom_range(0, 255));
         else if (pick < 9)
            w[i] = base + 8'($urandom_range(0, 4));
         else
            w[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : word_monitor
      win_type w;
      pix_type want;
      logic    moved;
      moved = 1'b0;
      if (!reset && win_ch.valid === 1'b1 && win_ch.ready === 1'b1) begin
         w[0] = win_ch.pix_top_left;
         w[1] = win_ch.pix_top_mid;
         w[2] = win_ch.pix_top_right;
         w[3] = win_ch.pix_mid_left;
         w[4] = win_ch.pix_center;
         w[5] = win_ch.pix_mid_right;
         w[6] = win_ch.pix_bot_left;
         w[7] = win_ch.pix_bot_mid;
         w[8] = win_ch.pix_bot_right;
         median_queue.push_back(median_of_window(w));
         moved = 1'b1;
      end
      if (!reset && med_ch.valid === 1'b1 && med_ch.ready === 1'b1) begin
         moved = 1'b1;
         if (median_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected median word %0d", med_ch.median_pixel));
         end else begin
            want = median_queue.pop_front();
            if (med_ch.median_pixel !== want)
               report_mismatch($sformatf("median_pixel got %0d expected %0d",
                                         med_ch.median_pixel, want));
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   initial begin : ready_pattern
      ready_mode_type mode;
      int             hold;
      logic [7:0]     pattern;
      med_ch.ready = 1'b0;
      mode         = READY_ALWAYS;
      hold         = 0;
      pattern      = 8'h00;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            mode    = ready_mode_type'($urandom_range(0, 3));
            hold    = $urandom_range(16, 160);
            pattern = 8'($urandom_range(1, 255));
         end
         hold--;
         unique case (mode)
            READY_ALWAYS:  med_ch.ready <= 1'b1;
            READY_COIN:    med_ch.ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  med_ch.ready <= ($urandom_range(0, 3) == 0);
            READY_PATTERN: begin
               med_ch.ready <= pattern[0];
               pattern = {pattern[0], pattern[7:1]};
            end
         endcase
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("median_filter_3x3_core verification failed");
      $finish;
   end

   task automatic send_window(input win_type w);
      @(negedge clock);
      win_ch.valid         <= 1'b1;
      win_ch.pix_top_left  <= w[0];
      win_ch.pix_top_mid   <= w[1];
      win_ch.pix_top_right <= w[2];
      win_ch.pix_mid_left  <= w[3];
      win_ch.pix_center    <= w[4];
      win_ch.pix_mid_right <= w[5];
      win_ch.pix_bot_left  <= w[6];
      win_ch.pix_bot_mid   <= w[7];
      win_ch.pix_bot_right <= w[8];
      do @(posedge clock); while (win_ch.ready !== 1'b1);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         @(negedge clock);
         win_ch.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_paced(input win_type w);
      if (burst_left == 0) begin
         idle_for($urandom_range(0, 6));
         burst_left = $urandom_range(1, 24);
      end
      send_window(w);
      burst_left--;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      win_ch.valid <= 1'b0;
      while (median_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      win_type w;
      w = '0;
      send_paced(w);
      w = '1;
      send_paced(w);
      w = {WIN_COUNT{8'h55}};
      send_paced(w);
      w = {WIN_COUNT{8'haa}};
      send_paced(w);
      w = '0;
      w[4] = 8'hff;
      send_paced(w);
      w = '1;
      w[0] = 8'h00;
      send_paced(w);
      for (int i = 0; i < WIN_COUNT; i++) w[i] = 8'h01 << (i % PIX_WIDTH);
      send_paced(w);
      for (int i = 0; i < WIN_COUNT; i++) w[i] = ~(8'h01 << (i % PIX_WIDTH));
      send_paced(w);
   endtask

   task automatic test_ties();
      win_type w;
      for (int i = 0; i < WIN_COUNT; i++) w[i] = (i < 4) ? 8'h00 : 8'hff;
      send_paced(shuffle_window(w));
      for (int i = 0; i < WIN_COUNT; i++) w[i] = (i < 5) ? 8'h00 : 8'hff;
      send_paced(shuffle_window(w));
      w = {WIN_COUNT{8'h80}};
      w[$urandom_range(0, WIN_COUNT - 1)] = 8'h7f;
      send_paced(w);
      for (int i = 0; i < WIN_COUNT; i++) w[i] = (i < 3) ? 8'h10 : ((i < 6) ? 8'h20 : 8'h30);
      send_paced(shuffle_window(w));
   endtask

   task automatic test_median_position();
      win_type w;
      win_type s;
      int      k;
      for (int p = 0; p < WIN_COUNT; p++) begin
         w = '0;
         for (int i = 0; i < WIN_COUNT - 1; i++)
            w[i] = (i < 4) ? 8'(10 + 10 * i) : 8'(160 + 20 * (i - 4));
         s = shuffle_window({8'd100, w[WIN_COUNT-2:0]});
         k = 0;
         for (int i = 0; i < WIN_COUNT; i++) begin
            if (s[i] == 8'd100) k = i;
         end
         s[k] = s[p];
         s[p] = 8'd100;
         send_paced(s);
      end
   endtask

   task automatic test_random_windows();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) wait_drained();
         send_paced(random_window());
      end
   endtask

   initial begin
      reset                = 1'b1;
      win_ch.valid         = 1'b0;
      win_ch.pix_top_left  = '0;
      win_ch.pix_top_mid   = '0;
      win_ch.pix_top_right = '0;
      win_ch.pix_mid_left  = '0;
      win_ch.pix_center    = '0;
      win_ch.pix_mid_right = '0;
      win_ch.pix_bot_left  = '0;
      win_ch.pix_bot_mid   = '0;
      win_ch.pix_bot_right = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_ties();
      test_median_position();
      test_random_windows();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("median_filter_3x3_core verification clean");
      else
         $display("median_filter_3x3_core verification failed");
      $finish;
   end

endmodule
